// ===== rtl/core/fpib_pkg.sv =====
// Shared types and constants of the five-point in-place blur.
package fpib_pkg;

	// Default line store depth, in pixels.
	localparam int MAX_ROW_PIXELS_DEF = 1024;

	// Pixel and field widths.
	localparam int PIX_W  = 32;
	localparam int LANE_W = 8;
	localparam int LANES  = PIX_W / LANE_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 11;
	localparam int ROW_W_W    = 11;
	localparam int FADE_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_MODE = 4'd1;

	localparam logic [ROW_W_W-1:0] ROW_WIDTH_RST = 11'd1024;

	// Fade selection; the unused code behaves as no fade.
	typedef enum logic [FADE_W-1:0] {
		FADE_NONE = 2'd0,
		FADE_UP   = 2'd1,
		FADE_DOWN = 2'd2
	} fade_t;

endpackage

// ===== rtl/core/fpib_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fpib_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/fpib_blend.sv =====
// Per-byte five-point weighted sum, divide by eight and saturating fade.
module fpib_blend (
	input  logic [fpib_pkg::PIX_W-1:0] center,
	input  logic [fpib_pkg::PIX_W-1:0] right,
	input  logic [fpib_pkg::PIX_W-1:0] below,
	input  logic [fpib_pkg::PIX_W-1:0] above,
	input  logic [fpib_pkg::PIX_W-1:0] left,
	input  fpib_pkg::fade_t            fade,
	output logic [fpib_pkg::PIX_W-1:0] result
);
	import fpib_pkg::*;

	// Five bytes with the center weighted by four sum to at most 2040.
	localparam int SUM_W = LANE_W + 3;

	always_comb begin
		logic [SUM_W-1:0]  sum;
		logic [LANE_W-1:0] avg;
		logic [LANE_W-1:0] faded;
		result = '0;
		for (int k = 0; k < LANES; k++) begin
			sum = SUM_W'(below[k*LANE_W +: LANE_W]) + SUM_W'(above[k*LANE_W +: LANE_W])
			    + SUM_W'(left[k*LANE_W +: LANE_W]) + SUM_W'(right[k*LANE_W +: LANE_W])
			    + {1'b0, center[k*LANE_W +: LANE_W], 2'b00};
			avg = sum[SUM_W-1:3];
			case (fade)
				FADE_UP: begin
					faded = (avg == '1) ? avg : avg + LANE_W'(1);
				end
				FADE_DOWN: begin
					faded = (avg == '0) ? avg : avg - LANE_W'(1);
				end
				default: begin
					faded = avg;
				end
			endcase
			result[k*LANE_W +: LANE_W] = faded;
		end
	end

endmodule

// ===== rtl/core/five_point_inplace_blur_top.sv =====
// Top level of the five-point in-place blur: handshakes, line store pipeline, configuration.
// The block takes one pixel per transfer in raster order and returns one blurred pixel per
// transfer, at one pixel per clock cycle while m_tready stays high. Each byte of the result is
// (below + above + left + right + 4*center) >> 3, where "above" is the blurred pixel this
// block produced one row earlier in the same column, kept in a line store of
// MAX_ROW_PIXELS words, and "left" is the raw center pixel of the previous transfer; an
// optional fade then adds or subtracts one per byte with saturation. The line store is read
// in the cycle of the input transfer; when stage one advances, the blended result is
// written back and loaded into the output register. When the same column is read while it
// is being written (a row one pixel wide), the fresh result is forwarded. After reset a
// clearing pass zeroes the line store, one entry per cycle; s_tready stays low during it,
// while configuration writes are taken at any time. Write configuration only while the
// block is idle. Register 0 is row_width (zero acts as one, values above MAX_ROW_PIXELS
// saturate), register 1 is fade_mode (0 none, 1 toward white, 2 toward black, 3 none);
// other indexes are ignored.
module five_point_inplace_blur_top #(
	parameter int MAX_ROW_PIXELS = fpib_pkg::MAX_ROW_PIXELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream. s_tdata: center_pixel [31:0], right_pixel [63:32], below_pixel [95:64].
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [3*fpib_pkg::PIX_W-1:0]       s_tdata,
	// Output stream. m_tdata: blurred_pixel [31:0].
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [fpib_pkg::PIX_W-1:0]         m_tdata,
	// Configuration writes.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fpib_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpib_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fpib_pkg::*;

	localparam int AW = $clog2(MAX_ROW_PIXELS);
	localparam int EW = AW + 1;

	// Configuration registers.
	logic [ROW_W_W-1:0] row_width_q;
	fade_t              fade_q;

	// Clearing pass over the line store.
	logic               clr_active_q;
	logic [AW-1:0]      clr_addr_q;

	// Position and left neighbor, advanced on each input transfer.
	logic [AW-1:0]      col_q;
	logic [PIX_W-1:0]   prev_q;

	// Stage one: line store data arrives here.
	logic               valid_s1;
	logic [PIX_W-1:0]   center_s1;
	logic [PIX_W-1:0]   right_s1;
	logic [PIX_W-1:0]   below_s1;
	logic [PIX_W-1:0]   left_s1;
	logic [AW-1:0]      col_s1;
	logic               byp_hit_s1;
	logic [PIX_W-1:0]   byp_data_s1;

	// Output register.
	logic               out_valid_q;
	logic [PIX_W-1:0]   out_data_q;

	logic [31:0]        width_wide;
	logic [31:0]        eff_wide;
	logic [EW-1:0]      eff_w;
	logic [AW-1:0]      col_cur;
	logic [EW-1:0]      col_inc;
	logic [AW-1:0]      col_next;
	logic               accept;
	logic               adv_s1;
	logic               item_we;
	logic [PIX_W-1:0]   ram_rdata;
	logic [PIX_W-1:0]   above;
	logic [PIX_W-1:0]   result;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [PIX_W-1:0]   ram_wdata;

	// Effective row width: zero acts as one, large values saturate to the store depth.
	assign width_wide = 32'(row_width_q);
	always_comb begin
		if (width_wide == '0) begin
			eff_wide = 32'd1;
		end else if (width_wide > 32'(MAX_ROW_PIXELS)) begin
			eff_wide = 32'(MAX_ROW_PIXELS);
		end else begin
			eff_wide = width_wide;
		end
	end
	assign eff_w = eff_wide[EW-1:0];

	// A column left beyond a narrowed width restarts the row.
	assign col_cur  = ({1'b0, col_q} >= eff_w) ? '0 : col_q;
	assign col_inc  = {1'b0, col_cur} + EW'(1);
	assign col_next = (col_inc >= eff_w) ? '0 : col_inc[AW-1:0];

	// Stage one moves on when the output register is empty or being drained.
	assign adv_s1   = !out_valid_q || m_tready;
	assign s_tready = !clr_active_q && (!valid_s1 || adv_s1);
	assign accept   = s_tvalid && s_tready;
	assign item_we  = valid_s1 && adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
			fade_q      <= FADE_NONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW_WIDTH: row_width_q <= cfg_data[ROW_W_W-1:0];
				REG_FADE_MODE: fade_q      <= fade_t'(cfg_data[FADE_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_ROW_PIXELS - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			prev_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				col_q  <= col_next;
				prev_q <= s_tdata[PIX_W-1:0];
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers of stage one. The read issued now returns the old word if stage one
	// writes the same column in this cycle, so that write is captured for forwarding.
	always_ff @(posedge clk) begin
		if (accept) begin
			center_s1   <= s_tdata[PIX_W-1:0];
			right_s1    <= s_tdata[2*PIX_W-1:PIX_W];
			below_s1    <= s_tdata[3*PIX_W-1:2*PIX_W];
			left_s1     <= prev_q;
			col_s1      <= col_cur;
			byp_hit_s1  <= item_we && (col_s1 == col_cur);
			byp_data_s1 <= result;
		end
	end

	always_ff @(posedge clk) begin
		if (item_we) begin
			out_data_q <= result;
		end
	end

	assign above = byp_hit_s1 ? byp_data_s1 : ram_rdata;

	fpib_blend u_blend (
		.center (center_s1),
		.right  (right_s1),
		.below  (below_s1),
		.above  (above),
		.left   (left_s1),
		.fade   (fade_q),
		.result (result)
	);

	// Line store write port: zeroes during the clearing pass, results afterwards.
	assign ram_we    = clr_active_q || item_we;
	assign ram_waddr = clr_active_q ? clr_addr_q : col_s1;
	assign ram_wdata = clr_active_q ? '0 : result;

	fpib_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_ROW_PIXELS)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (col_cur),
		.rdata (ram_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// No pixel enters while the line store is still being cleared.
	a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !s_tready)
		else $error("input accepted during the clearing pass");

	// An accepted pixel always occupies stage one on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted pixel lost before stage one");

	// A pixel blocked in stage one is not dropped.
	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> valid_s1 && $stable(col_s1))
		else $error("stage one changed while stalled");

	// The tracked column never runs past the line store.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < EW'(MAX_ROW_PIXELS))
		else $error("column position beyond the line store");

endmodule

// ===== tb/fpib_blur_monitor.sv =====
// Stream monitor of the five-point blur: tracks configuration, predicts each pixel, compares.
`timescale 1ns / 100ps

module fpib_blur_monitor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [3*fpib_pkg::PIX_W-1:0]        s_tdata,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [fpib_pkg::PIX_W-1:0]          m_tdata,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [fpib_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpib_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  results_seen
);
	import fpib_pkg::*;

	localparam int DEPTH      = MAX_ROW_PIXELS_DEF;
	localparam int SHOW_LIMIT = 10;

	logic [PIX_W-1:0]   above_row [DEPTH];
	logic [PIX_W-1:0]   left_raw;
	int unsigned        col_pos;
	logic [ROW_W_W-1:0] width_reg;
	logic [FADE_W-1:0]  fade_reg;
	logic [PIX_W-1:0]   expected_blur_q [$];
	logic [PIX_W-1:0]   want;
	int                 mismatches;
	int                 checked;

	// Blurs one pixel and advances the line store, the left pixel and the column.
	function automatic logic [PIX_W-1:0] blur_step(input logic [PIX_W-1:0] center,
			input logic [PIX_W-1:0] right, input logic [PIX_W-1:0] below);
		int unsigned      span;
		int unsigned      col;
		int unsigned      total;
		int unsigned      v;
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] blurred;
		span = 32'(width_reg);
		if (span == 0)
			span = 1;
		if (span > DEPTH)
			span = DEPTH;
		col = col_pos;
		if (col >= span)
			col = 0;
		up = above_row[col];
		blurred = '0;
		for (int k = 0; k < LANES; k++) begin
			total = below[k*LANE_W +: LANE_W] + up[k*LANE_W +: LANE_W]
				+ left_raw[k*LANE_W +: LANE_W] + right[k*LANE_W +: LANE_W]
				+ 4 * center[k*LANE_W +: LANE_W];
			v = total >> 3;
			if (fade_reg == FADE_UP)
				v = (v == 255) ? 255 : v + 1;
			else if (fade_reg == FADE_DOWN)
				v = (v == 0) ? 0 : v - 1;
			blurred[k*LANE_W +: LANE_W] = v[LANE_W-1:0];
		end
		above_row[col] = blurred;
		left_raw = center;
		col = col + 1;
		if (col >= span)
			col = 0;
		col_pos = col;
		return blurred;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				above_row[i] = '0;
			left_raw = '0;
			col_pos = 0;
			width_reg = ROW_WIDTH_RST;
			fade_reg = FADE_NONE;
			expected_blur_q.delete();
			mismatches = 0;
			checked = 0;
			fail_count <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROW_WIDTH)
					width_reg = cfg_data[ROW_W_W-1:0];
				else if (cfg_index == REG_FADE_MODE)
					fade_reg = cfg_data[FADE_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (expected_blur_q.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("[%0t] unexpected blurred_pixel %08h", $realtime, m_tdata);
				end else begin
					want = expected_blur_q.pop_front();
					checked++;
					if (m_tdata !== want) begin
						mismatches++;
						if (mismatches <= SHOW_LIMIT)
							$display("[%0t] blurred_pixel mismatch: expected %08h, got %08h",
								$realtime, want, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_blur_q.push_back(blur_step(s_tdata[PIX_W-1:0],
					s_tdata[2*PIX_W-1:PIX_W], s_tdata[3*PIX_W-1:2*PIX_W]));
			fail_count <= mismatches;
			pending <= expected_blur_q.size();
			results_seen <= checked;
		end
	end

endmodule

// ===== tb/tb_five_point_inplace_blur_top.sv =====
// Testbench top of the five-point blur: clock, reset, stimulus phases and the verdict.
`timescale 1ns / 100ps

module tb_five_point_inplace_blur_top;
	import fpib_pkg::*;

	localparam int ITEMS_PER_PHASE = 230;
	localparam int PHASES          = 8;
	// The limit leaves a wide margin over a typical run, including the clearing pass after
	// reset.
	localparam int CYCLE_LIMIT     = 300000;
	// A pixel passes only stage one and the output register, so a short tail is enough.
	localparam int TAIL_CYCLES     = 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [3*PIX_W-1:0]     s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [PIX_W-1:0]       m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int fail_count;
	int pending;
	int results_seen;
	int cycle_count = 0;

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	five_point_inplace_blur_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fpib_blur_monitor u_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// Watchdog. A hang anywhere, including a clearing pass that never ends, lands here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d pixels outstanding",
				cycle_count, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Output side: the ready line is redrawn every cycle from the current stall rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// One register write. The valid line is dropped and seen low at a clock edge before the
	// task returns, so a following write never lowers and raises it within the same time step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One pixel transfer, preceded by a random number of idle cycles. Valid stays high
	// between back-to-back pixels and is only lowered when a gap is actually inserted.
	task automatic send_pixel(input logic [PIX_W-1:0] center, input logic [PIX_W-1:0] right,
			input logic [PIX_W-1:0] below);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {below, right, center};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops the input, waits for every predicted pixel to come out, then lets the
	// pipeline run on through a short tail so the block is truly idle before a register write.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Random pixel with bytes biased toward the extremes, so saturation and large
	// sums show up often; some pixels are fully random or flat.
	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] px;
		case ($urandom_range(7))
			0: px = $urandom();
			1: px = '0;
			2: px = '1;
			default: begin
				for (int k = 0; k < LANES; k++) begin
					case ($urandom_range(3))
						0: px[k*LANE_W +: LANE_W] = 8'h00;
						1: px[k*LANE_W +: LANE_W] = 8'hFF;
						default: px[k*LANE_W +: LANE_W] = LANE_W'($urandom_range(255));
					endcase
				end
			end
		endcase
		return px;
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] width_val;
		logic [FADE_W-1:0]     fade_val;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Narrow rows first, so the second row already reads back what the
		// first one wrote, and the left pixel carries over from the end of each row.
		write_reg(REG_ROW_WIDTH, CFG_DATA_W'(4));
		write_reg(REG_FADE_MODE, CFG_DATA_W'(FADE_NONE));
		send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_pixel(32'h00FF_00FF, 32'hFF00_FF00, 32'h0F0F_0F0F);
		send_pixel(32'h8080_8080, 32'h7F7F_7F7F, 32'h0102_0408);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'h1234_5678, 32'hFEDC_BA98, 32'h5555_AAAA);
		settle_block();

		// A row one pixel wide reads the column it has just written, which exercises the
		// forwarding path; white input drives every byte up toward 254.
		write_reg(REG_ROW_WIDTH, CFG_DATA_W'(1));
		repeat (5) send_pixel('1, '1, '1);
		settle_block();

		// Fade toward white on a bright column: the bytes reach 255 and then saturate.
		write_reg(REG_FADE_MODE, CFG_DATA_W'(FADE_UP));
		repeat (3) send_pixel('1, '1, '1);
		settle_block();

		// Fade toward black on black input: the bytes fall to zero and stay there.
		write_reg(REG_FADE_MODE, CFG_DATA_W'(FADE_DOWN));
		repeat (4) send_pixel('0, '0, '0);
		settle_block();

		// The unused fade code and a zero width, which must act as no fade and width one.
		write_reg(REG_FADE_MODE, CFG_DATA_W'(3));
		write_reg(REG_ROW_WIDTH, CFG_DATA_W'(0));
		send_pixel(pick_pixel(), pick_pixel(), pick_pixel());
		send_pixel(pick_pixel(), pick_pixel(), pick_pixel());
		settle_block();

		// The largest width saturates to the line store depth; writes to unknown
		// indexes must leave both registers alone.
		write_reg(REG_ROW_WIDTH, '1);
		write_reg(CFG_IDX_W'(2), CFG_DATA_W'(5));
		write_reg('1, '0);
		send_pixel(pick_pixel(), pick_pixel(), pick_pixel());
		send_pixel(pick_pixel(), pick_pixel(), pick_pixel());
		settle_block();

		// Random phases. Each idling mix comes up twice, each time with another width but the
		// same fade code. Rows are not realigned between phases, so a new width often lands in
		// the middle of a row.
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 78;
					recv_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct = 78;
				end
				default: begin
					sender_idle_pct = 25;
					recv_stall_pct = 25;
				end
			endcase
			case (p)
				0: width_val = CFG_DATA_W'(4);
				1: width_val = CFG_DATA_W'(1024);
				2: width_val = CFG_DATA_W'(1);
				3: width_val = CFG_DATA_W'(16);
				4: width_val = '1;
				5: width_val = CFG_DATA_W'(12);
				6: width_val = '0;
				default: width_val = CFG_DATA_W'(4 * $urandom_range(1, 256));
			endcase
			fade_val = FADE_W'(p % 4);
			write_reg(REG_ROW_WIDTH, width_val);
			// Bits above the fade field are don't-care and get random values.
			write_reg(REG_FADE_MODE,
				{(CFG_DATA_W-FADE_W)'($urandom_range(511)), fade_val});
			repeat (ITEMS_PER_PHASE) send_pixel(pick_pixel(), pick_pixel(), pick_pixel());
			settle_block();
		end

		$display("Checked %0d blurred pixels: directed edge cases plus %0d random phases,",
			results_seen, PHASES);
		$display("widths 0 to 2047, all four fade codes, idle and stall mixes on both sides.");
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== five_point_inplace_blur_top.f =====
rtl/core/fpib_pkg.sv
rtl/core/fpib_ram.sv
rtl/core/fpib_blend.sv
rtl/core/five_point_inplace_blur_top.sv
tb/fpib_blur_monitor.sv
tb/tb_five_point_inplace_blur_top.sv
